FILE: hw/rtl/rsgm_pkg.sv
`default_nettype none

package rsgm_pkg;

  localparam int unsigned IdW    = 8;
  localparam int unsigned SeqW   = 8;
  localparam int unsigned StatW  = 8;
  localparam int unsigned STimeW = 64;
  localparam int unsigned HTimeW = 32;
  localparam int unsigned CntW   = 32;
  localparam int unsigned HitW   = 2;

  // Operation field of a request.
  localparam logic OpRecord = 1'b0;
  localparam logic OpClear  = 1'b1;

  // Stream hit code when no stream was updated.
  localparam logic [HitW-1:0] HitNone = 2'd2;

  // Configuration register indexes and reset values.
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = IdW;
  localparam logic [CfgIdxW-1:0] CfgAccelId = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgGyroId  = 1'd1;
  localparam logic [IdW-1:0] AccelIdReset = 8'd1;
  localparam logic [IdW-1:0] GyroIdReset  = 8'd2;

  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic              operation;
    logic [IdW-1:0]    sensor_id;
    logic [SeqW-1:0]   sequence_req;
    logic [StatW-1:0]  status;
    logic [STimeW-1:0] sensor_time_us;
    logic [HTimeW-1:0] host_time_us;
  } req_t;

  typedef struct packed {
    logic [HitW-1:0]   stream_hit;
    logic [CntW-1:0]   received_count;
    logic [CntW-1:0]   gap_count;
    logic [CntW-1:0]   advance_count;
    logic [CntW-1:0]   backstep_count;
    logic [STimeW-1:0] first_sensor_time;
    logic [STimeW-1:0] last_sensor_time;
    logic [HTimeW-1:0] first_host_time;
    logic [HTimeW-1:0] last_host_time;
    logic [StatW-1:0]  last_status_byte;
    logic [SeqW-1:0]   last_sequence_number;
  } rsp_t;

  typedef enum logic [1:0] {
    CmdRecord,
    CmdClear,
    CmdIgnore
  } cmd_kind_e;

  // Classified request handed from the front end to the update engine.
  typedef struct packed {
    cmd_kind_e         kind;
    logic              sel;
    logic [SeqW-1:0]   seq;
    logic [StatW-1:0]  status;
    logic [STimeW-1:0] stime;
    logic [HTimeW-1:0] htime;
  } cmd_t;

  // Statistics kept for one stream.
  typedef struct packed {
    logic              seen;
    logic [CntW-1:0]   received;
    logic [CntW-1:0]   gaps;
    logic [CntW-1:0]   advances;
    logic [CntW-1:0]   backsteps;
    logic [STimeW-1:0] first_sensor;
    logic [STimeW-1:0] last_sensor;
    logic [HTimeW-1:0] first_host;
    logic [HTimeW-1:0] last_host;
    logic [SeqW-1:0]   last_seq;
    logic [StatW-1:0]  last_status;
  } stats_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rsgm_stream_if.sv
`default_nettype none

interface rsgm_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/rsgm_front.sv
`default_nettype none

module rsgm_front #(
  parameter int unsigned NUM_STREAMS = 2
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [rsgm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [rsgm_pkg::CfgDataW-1:0] cfg_data_i,
  rsgm_stream_if.sink                       req_if_i,
  input  wire logic                         full_i,
  output logic                              push_o,
  output rsgm_pkg::cmd_t                    cmd_o
);
  import rsgm_pkg::*;

  logic [IdW-1:0] accel_id_q, accel_id_d;
  logic [IdW-1:0] gyro_id_q, gyro_id_d;

  always_comb begin
    accel_id_d = accel_id_q;
    gyro_id_d  = gyro_id_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgAccelId: accel_id_d = cfg_data_i;
        CfgGyroId:  gyro_id_d  = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_id_q <= AccelIdReset;
      gyro_id_q  <= GyroIdReset;
    end else begin
      accel_id_q <= accel_id_d;
      gyro_id_q  <= gyro_id_d;
    end
  end

  assign req_if_i.ready = !full_i;
  assign push_o         = req_if_i.valid && !full_i;

  // The accelerometer id wins when both registers hold the same value.
  always_comb begin
    cmd_o.sel    = 1'b0;
    cmd_o.seq    = req_if_i.payload.sequence_req;
    cmd_o.status = req_if_i.payload.status;
    cmd_o.stime  = req_if_i.payload.sensor_time_us;
    cmd_o.htime  = req_if_i.payload.host_time_us;
    if (req_if_i.payload.operation == OpClear) begin
      cmd_o.kind = CmdClear;
    end else if (req_if_i.payload.sensor_id == accel_id_q) begin
      cmd_o.kind = CmdRecord;
    end else if ((req_if_i.payload.sensor_id == gyro_id_q) && (NUM_STREAMS > 1)) begin
      cmd_o.kind = CmdRecord;
      cmd_o.sel  = 1'b1;
    end else begin
      cmd_o.kind = CmdIgnore;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rsgm_queue.sv
`default_nettype none

module rsgm_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire rsgm_pkg::cmd_t push_data_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output rsgm_pkg::cmd_t      pop_data_o,
  output logic                empty_o
);
  import rsgm_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntBits = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);

  cmd_t                slot_q [QueueDepth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0]  count_q, count_d;

  assign full_o     = (count_q == CntBits'(QueueDepth));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rsgm_back.sv
`default_nettype none

module rsgm_back #(
  parameter int unsigned NUM_STREAMS = 2
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           empty_i,
  input  wire rsgm_pkg::cmd_t cmd_i,
  output logic                pop_o,
  rsgm_stream_if.source       rsp_if_o
);
  import rsgm_pkg::*;

  // Only the accelerometer and gyroscope streams can ever be selected.
  localparam int unsigned NumLive = (NUM_STREAMS < 2) ? NUM_STREAMS : 2;
  localparam int unsigned IdxW = (NumLive > 1) ? $clog2(NumLive) : 1;

  stats_t          stats_q [NumLive];
  stats_t          cur, nxt;
  logic [IdxW-1:0] idx;
  logic [SeqW-1:0] diff;
  logic [STimeW-1:0] base_last;
  logic            out_valid_q;
  rsp_t            rsp_q, rsp_d;

  assign pop_o = !empty_i && (!out_valid_q || rsp_if_o.ready);
  assign idx   = IdxW'(cmd_i.sel);
  assign cur   = stats_q[idx];
  assign diff  = cmd_i.seq - cur.last_seq;

  always_comb begin
    nxt             = cur;
    nxt.seen        = 1'b1;
    nxt.received    = cur.received + 1'b1;
    nxt.last_seq    = cmd_i.seq;
    nxt.last_status = cmd_i.status;
    nxt.last_host   = cmd_i.htime;
    if (!cur.seen) begin
      nxt.first_sensor = cmd_i.stime;
      nxt.first_host   = cmd_i.htime;
      base_last        = cmd_i.stime;
    end else begin
      base_last    = cur.last_sensor;
      nxt.advances = cur.advances + CntW'(diff);
      if (diff > SeqW'(1)) begin
        nxt.gaps = cur.gaps + CntW'(diff - 1'b1);
      end
    end
    if (cmd_i.stime >= base_last) begin
      nxt.last_sensor = cmd_i.stime;
    end else begin
      nxt.last_sensor = base_last;
      nxt.backsteps   = cur.backsteps + 1'b1;
    end
  end

  always_comb begin
    rsp_d            = '0;
    rsp_d.stream_hit = HitNone;
    if (cmd_i.kind == CmdRecord) begin
      rsp_d.stream_hit           = {1'b0, cmd_i.sel};
      rsp_d.received_count       = nxt.received;
      rsp_d.gap_count            = nxt.gaps;
      rsp_d.advance_count        = nxt.advances;
      rsp_d.backstep_count       = nxt.backsteps;
      rsp_d.first_sensor_time    = nxt.first_sensor;
      rsp_d.last_sensor_time     = nxt.last_sensor;
      rsp_d.first_host_time      = nxt.first_host;
      rsp_d.last_host_time       = nxt.last_host;
      rsp_d.last_status_byte     = nxt.last_status;
      rsp_d.last_sequence_number = nxt.last_seq;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumLive; i++) begin
        stats_q[i] <= '0;
      end
    end else if (pop_o) begin
      if (cmd_i.kind == CmdClear) begin
        for (int i = 0; i < NumLive; i++) begin
          stats_q[i] <= '0;
        end
      end else if (cmd_i.kind == CmdRecord) begin
        stats_q[idx] <= nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (rsp_if_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_if_o.valid   = out_valid_q;
  assign rsp_if_o.payload = rsp_q;

endmodule

`default_nettype wire

FILE: hw/rtl/report_stream_gap_monitor.sv
`default_nettype none

// Channel    Dir  Payload           Transfer
// req_if_i   in   rsgm_pkg::req_t   valid && ready at a rising clk_i edge
// rsp_if_o   out  rsgm_pkg::rsp_t   valid && ready at a rising clk_i edge
// cfg        in   cfg_idx_i/data_i  cfg_we_i high at a rising clk_i edge
//
// One request is taken every cycle while the queue is not full, and each
// request produces exactly one response; the rate is set by the read-modify-write
// of the per-stream statistics registers. A request is registered in the queue,
// then in the output register. rst_ni clears the statistics and restores the
// default stream ids at once, with no sweep. A stalled response holds in the
// output register while the two-entry queue keeps taking requests until it fills.

module report_stream_gap_monitor #(
  parameter int unsigned NUM_STREAMS = 2
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [rsgm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [rsgm_pkg::CfgDataW-1:0] cfg_data_i,
  rsgm_stream_if.sink                        req_if_i,
  rsgm_stream_if.source                      rsp_if_o
);
  import rsgm_pkg::*;

  // The front end compares the sensor id against the two configured ids and
  // turns each request into a record, clear or ignore command.
  logic full;
  logic push;
  cmd_t push_cmd;

  // The back end pops a command whenever its output register is free or is
  // being emptied in the same cycle, so the two sides stall independently.
  logic empty;
  logic pop;
  cmd_t pop_cmd;

  rsgm_front #(
    .NUM_STREAMS (NUM_STREAMS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_if_i   (req_if_i),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  rsgm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_cmd),
    .empty_o     (empty)
  );

  // Statistics for the selected stream are updated and the response is
  // built from the updated values in the same cycle.
  rsgm_back #(
    .NUM_STREAMS (NUM_STREAMS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .empty_i  (empty),
    .cmd_i    (pop_cmd),
    .pop_o    (pop),
    .rsp_if_o (rsp_if_o)
  );

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking bench for the two-stream report gap monitor. Requests are queued
// by the main sequence and fed to the block by a clocked driver. Each accepted
// request is run through a behavioral copy of the per-stream statistics, and the
// snapshot that copy produces is queued. A clocked monitor compares every
// response with the oldest queued snapshot, field by field.
module tb_top;
  import rsgm_pkg::*;

  localparam int unsigned NumStreams = 2;
  localparam int unsigned CycleLimit = 200000;
  // How many cycles the response side holds off during the back-pressure test.
  // This is far longer than the two-entry queue plus the output register can absorb.
  localparam int unsigned LongHold   = 60;
  // Extra cycles after draining, enough to see any stray response.
  localparam int unsigned TailCycles = 8;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  rsgm_stream_if #(.payload_t(req_t)) req_ch ();
  rsgm_stream_if #(.payload_t(rsp_t)) rsp_ch ();

  report_stream_gap_monitor #(
    .NUM_STREAMS(NumStreams)
  ) uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .req_if_i  (req_ch),
    .rsp_if_o  (rsp_ch)
  );

  always #10 clk_i = ~clk_i;

  // Requests waiting to be offered, and the snapshots the block must return.
  req_t pending_events[$];
  rsp_t expected_snapshots[$];

  // Our own copy of the stream ids and of every stream's statistics.
  logic [IdW-1:0] accel_id_cur;
  logic [IdW-1:0] gyro_id_cur;
  stats_t         model_stats [NumStreams];

  // Per-stream sequence and timestamp trackers for the random traffic.
  logic [SeqW-1:0]   seq_next   [NumStreams];
  logic [STimeW-1:0] stamp_next [NumStreams];

  logic        offering;
  int unsigned send_gap;
  int unsigned stall_left;
  logic        rsp_ready_q;
  logic        idle_on;
  logic        long_hold_req;
  logic        long_hold_done;
  int unsigned error_count;
  int unsigned cycle_count;
  rsp_t        snapshot_want;

  // Apply one request to the statistics copy and return the snapshot that
  // the block should answer with.
  function automatic rsp_t update_stream_model(req_t ev);
    rsp_t            snap;
    int unsigned     s;
    logic [SeqW-1:0] step;
    stats_t          st;
    snap            = '0;
    snap.stream_hit = HitNone;
    if (ev.operation == OpClear) begin
      foreach (model_stats[i]) model_stats[i] = '0;
      return snap;
    end
    // When both ids are equal, the accelerometer check comes first and wins.
    if (ev.sensor_id == accel_id_cur) s = 0;
    else if (ev.sensor_id == gyro_id_cur) s = 1;
    else return snap;
    if (s >= NumStreams) return snap;

    st = model_stats[s];
    if (!st.seen) begin
      // On the first report after a clear, we only latch times and count no sequence gap.
      st.first_sensor = ev.sensor_time_us;
      st.last_sensor  = ev.sensor_time_us;
      st.first_host   = ev.host_time_us;
      st.seen         = 1'b1;
    end else begin
      // The sequence difference wraps at eight bits.
      // A repeated number adds nothing to the gap and advance counts.
      step = ev.sequence_req - st.last_seq;
      if (step > 1) st.gaps = st.gaps + 32'(step) - 32'd1;
      st.advances = st.advances + 32'(step);
    end
    st.received    = st.received + 32'd1;
    st.last_seq    = ev.sequence_req;
    st.last_status = ev.status;
    st.last_host   = ev.host_time_us;
    // A timestamp that goes backwards is counted, and the last kept time stays as it was.
    if (ev.sensor_time_us >= st.last_sensor) st.last_sensor = ev.sensor_time_us;
    else st.backsteps = st.backsteps + 32'd1;
    model_stats[s] = st;

    snap.stream_hit           = HitW'(s);
    snap.received_count       = st.received;
    snap.gap_count            = st.gaps;
    snap.advance_count        = st.advances;
    snap.backstep_count       = st.backsteps;
    snap.first_sensor_time    = st.first_sensor;
    snap.last_sensor_time     = st.last_sensor;
    snap.first_host_time      = st.first_host;
    snap.last_host_time       = st.last_host;
    snap.last_status_byte     = st.last_status;
    snap.last_sequence_number = st.last_seq;
    return snap;
  endfunction

  function automatic void check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  // Request driver. Once a request is accepted, it goes through the model.
  // The driver then sometimes waits a random gap, if idling is on, before it offers the next one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_ch.valid   <= 1'b0;
      req_ch.payload <= '0;
      offering = 1'b0;
      send_gap = 0;
    end else begin
      if (offering && req_ch.ready) begin
        expected_snapshots.push_back(update_stream_model(req_ch.payload));
        offering = 1'b0;
        if (idle_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 9);
      end
      if (!offering) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_events.size() > 0) begin
          req_ch.payload <= pending_events.pop_front();
          offering = 1'b1;
        end
      end
      req_ch.valid <= offering;
    end
  end

  // Response monitor. It checks every accepted response, and it drives ready low in random bursts.
  // It also holds ready low once for a long stretch when the sequence asks for that.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
      rsp_ready_q    = 1'b0;
      stall_left     = 0;
      long_hold_done = 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ready_q) begin
        if (expected_snapshots.size() == 0) begin
          $display("%0t: unexpected response: expected none, actual stream_hit %0d",
                   $time, rsp_ch.payload.stream_hit);
          error_count++;
        end else begin
          snapshot_want = expected_snapshots.pop_front();
          check_field("stream_hit", rsp_ch.payload.stream_hit, snapshot_want.stream_hit);
          check_field("received_count", rsp_ch.payload.received_count,
                      snapshot_want.received_count);
          check_field("gap_count", rsp_ch.payload.gap_count, snapshot_want.gap_count);
          check_field("advance_count", rsp_ch.payload.advance_count,
                      snapshot_want.advance_count);
          check_field("backstep_count", rsp_ch.payload.backstep_count,
                      snapshot_want.backstep_count);
          check_field("first_sensor_time", rsp_ch.payload.first_sensor_time,
                      snapshot_want.first_sensor_time);
          check_field("last_sensor_time", rsp_ch.payload.last_sensor_time,
                      snapshot_want.last_sensor_time);
          check_field("first_host_time", rsp_ch.payload.first_host_time,
                      snapshot_want.first_host_time);
          check_field("last_host_time", rsp_ch.payload.last_host_time,
                      snapshot_want.last_host_time);
          check_field("last_status_byte", rsp_ch.payload.last_status_byte,
                      snapshot_want.last_status_byte);
          check_field("last_sequence_number", rsp_ch.payload.last_sequence_number,
                      snapshot_want.last_sequence_number);
        end
      end
      if (long_hold_req && !long_hold_done) begin
        stall_left     = LongHold;
        long_hold_done = 1'b1;
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_ready_q = 1'b0;
      end else begin
        rsp_ready_q = 1'b1;
        if (idle_on && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 9);
      end
      rsp_ch.ready <= rsp_ready_q;
    end
  end

  // This watchdog ends the run if it ever hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic queue_report(logic [IdW-1:0] id, logic [SeqW-1:0] seq,
                              logic [StatW-1:0] stat, logic [STimeW-1:0] stime,
                              logic [HTimeW-1:0] htime);
    req_t ev;
    ev.operation      = OpRecord;
    ev.sensor_id      = id;
    ev.sequence_req   = seq;
    ev.status         = stat;
    ev.sensor_time_us = stime;
    ev.host_time_us   = htime;
    pending_events.push_back(ev);
  endtask

  // A clear must ignore every other field, so we fill those fields with random values.
  task automatic queue_clear();
    req_t ev;
    ev.operation      = OpClear;
    ev.sensor_id      = ($urandom_range(0, 1) == 0) ? accel_id_cur : IdW'($urandom);
    ev.sequence_req   = SeqW'($urandom);
    ev.status         = StatW'($urandom);
    ev.sensor_time_us = {$urandom, $urandom};
    ev.host_time_us   = $urandom;
    pending_events.push_back(ev);
  endtask

  // Most random traffic is well-formed report streams on the two configured ids.
  // In those streams the sequence mostly steps by one and the timestamps mostly climb.
  // The rest is repeats, gaps, backward steps, unknown ids and clears.
  // Requests with an unknown id do not count toward the target.
  task automatic queue_random_traffic(int unsigned target);
    int unsigned    done;
    int unsigned    pick;
    int unsigned    s;
    logic [IdW-1:0] id;
    done = 0;
    while (done < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        queue_clear();
        done++;
      end else if (pick < 10) begin
        id = IdW'($urandom);
        if (id != accel_id_cur && id != gyro_id_cur)
          queue_report(id, SeqW'($urandom), StatW'($urandom), {$urandom, $urandom},
                       $urandom);
      end else begin
        s  = $urandom_range(0, NumStreams - 1);
        id = (s == 0) ? accel_id_cur : gyro_id_cur;
        pick = $urandom_range(0, 99);
        if (pick < 75) seq_next[s] = seq_next[s] + 8'd1;
        else if (pick < 85) seq_next[s] = seq_next[s];
        else if (pick < 95) seq_next[s] = seq_next[s] + SeqW'($urandom_range(2, 6));
        else seq_next[s] = SeqW'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 80) stamp_next[s] = stamp_next[s] + STimeW'($urandom_range(1, 5000));
        else if (pick < 88) stamp_next[s] = stamp_next[s] - STimeW'($urandom_range(1, 1000));
        else if (pick < 93) stamp_next[s] = stamp_next[s];
        else stamp_next[s] = {$urandom, $urandom};
        queue_report(id, seq_next[s], StatW'($urandom), stamp_next[s], $urandom);
        done++;
      end
    end
  endtask

  // Every request gives exactly one response. Once nothing is queued, nothing is being
  // offered and nothing is expected, the block is idle.
  task automatic wait_drained();
    while (pending_events.size() != 0 || offering || expected_snapshots.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    if (idx == CfgAccelId) accel_id_cur = data;
    else if (idx == CfgGyroId) gyro_id_cur = data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_stream_ids(logic [IdW-1:0] accel, logic [IdW-1:0] gyro);
    wait_drained();
    write_reg(CfgAccelId, accel);
    write_reg(CfgGyroId, gyro);
  endtask

  initial begin
    // Every input and every piece of testbench state starts at a known value.
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_data_i     = '0;
    req_ch.valid   = 1'b0;
    req_ch.payload = '0;
    rsp_ch.ready   = 1'b0;
    offering       = 1'b0;
    send_gap       = 0;
    stall_left     = 0;
    rsp_ready_q    = 1'b0;
    idle_on        = 1'b1;
    long_hold_req  = 1'b0;
    long_hold_done = 1'b0;
    error_count    = 0;
    cycle_count    = 0;
    accel_id_cur   = AccelIdReset;
    gyro_id_cur    = GyroIdReset;
    foreach (model_stats[i]) begin
      model_stats[i] = '0;
      seq_next[i]    = SeqW'($urandom);
      stamp_next[i]  = {$urandom, $urandom} >> 8;
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The directed part uses the default ids.
    // It covers the wrapping sequence, a repeat, a gap, a full wrap and the time extremes.
    // It also covers backward steps, unknown ids and a clear in the middle of a stream.
    queue_clear();
    queue_report(AccelIdReset, 8'hFF, 8'h00, 64'd0, 32'd0);
    queue_report(AccelIdReset, 8'h00, 8'hFF, 64'd1000, 32'hFFFF_FFFF);
    queue_report(AccelIdReset, 8'h00, 8'h5A, 64'd1000, 32'd1);
    queue_report(AccelIdReset, 8'h05, 8'hA5, 64'd900, 32'd2);
    queue_report(AccelIdReset, 8'h04, 8'h01, 64'd2000, 32'd3);
    queue_report(AccelIdReset, 8'h04, 8'h80, 64'hFFFF_FFFF_FFFF_FFFF, 32'h8000_0000);
    queue_report(AccelIdReset, 8'h06, 8'h7F, 64'd0, 32'h7FFF_FFFF);
    queue_report(GyroIdReset, 8'h80, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    queue_report(GyroIdReset, 8'h81, 8'h00, 64'hFFFF_FFFF_FFFF_FFFE, 32'd0);
    queue_report(8'h00, 8'h55, 8'h55, 64'h5555_5555_5555_5555, 32'h5555_5555);
    queue_report(8'hFF, 8'hAA, 8'hAA, 64'hAAAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA);
    queue_report(8'h03, 8'h01, 8'h01, 64'd1, 32'd1);
    queue_clear();
    queue_report(GyroIdReset, 8'h00, 8'h10, 64'd500, 32'd7);
    queue_report(AccelIdReset, 8'h00, 8'h20, 64'd600, 32'd8);
    queue_report(AccelIdReset, 8'h01, 8'h21, 64'd700, 32'd9);
    queue_report(GyroIdReset, 8'h03, 8'h11, 64'd400, 32'd10);

    // The ids go to opposite extremes here, and the random traffic starts.
    set_stream_ids(8'h00, 8'hFF);
    queue_random_traffic(150);

    // The ids are swapped at the extremes. In this phase the response side holds off
    // long enough for the input to stall while requests keep coming.
    set_stream_ids(8'hFF, 8'h00);
    queue_random_traffic(150);
    long_hold_req = 1'b1;

    // Both ids are equal, so every match goes to the accelerometer stream.
    set_stream_ids(8'd7, 8'd7);
    queue_random_traffic(50);

    set_stream_ids(IdW'($urandom_range(8, 127)), IdW'($urandom_range(128, 255)));
    queue_random_traffic(150);

    // The last phase runs back to back, with no idling on either side.
    wait_drained();
    idle_on = 1'b0;
    set_stream_ids(AccelIdReset, GyroIdReset);
    queue_random_traffic(150);

    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (error_count == 0 && expected_snapshots.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
